>>> hdl/pftk_pkg.sv
package pftk_pkg;

    localparam int ANGLE_BITS  = 16;
    localparam int TRIG_STAGES = 16;
    localparam int TABLE_LEN   = 24;
    localparam int ROT_STAGES  = (TRIG_STAGES < TABLE_LEN) ? TRIG_STAGES : TABLE_LEN;
    localparam int PIPE_STAGES = ROT_STAGES + 4;

    localparam int IN_W    = 16;
    localparam int PHASE_W = 32;
    localparam int XY_W    = 33;
    localparam int LEN_W   = 16;
    localparam int PROD_W  = LEN_W + 1 + XY_W;
    localparam int FRAC_W  = 30;
    localparam int RND_W   = PROD_W - FRAC_W;
    localparam int TERM_W  = 17;
    localparam int TIP_W   = 18;

    typedef logic signed [IN_W-1:0]   angle_t;
    typedef logic        [LEN_W-1:0]  link_len_t;
    typedef logic signed [TERM_W-1:0] elbow_pos_t;
    typedef logic signed [TIP_W-1:0]  tip_pos_t;
    typedef logic        [0:0]        cfg_index_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam cfg_index_t REG_FIRST_LINK  = 1'b0;
    localparam cfg_index_t REG_SECOND_LINK = 1'b1;

    localparam link_len_t LINK_RESET = 16'd512;

    localparam logic [PHASE_W-1:0] ANGLE_MASK =
        {PHASE_W{1'b1}} << (PHASE_W - ANGLE_BITS);
    localparam logic [PHASE_W-1:0] QUARTER = 32'h4000_0000;
    localparam logic [PHASE_W-1:0] EIGHTH  = 32'h2000_0000;

    localparam logic signed [XY_W-1:0] START_MAG = 33'sd652032874;
    localparam logic signed [RND_W-1:0] TERM_LIMIT = 20'sd65535;
    localparam prod_t ROUND_HALF = prod_t'(1) <<< (FRAC_W - 1);

    localparam logic [PHASE_W-1:0] ARC_TABLE [0:TABLE_LEN-1] = '{
        32'h20000000, 32'h12e4051d, 32'h09fb385b, 32'h051111d4,
        32'h028b0d43, 32'h0145d7e1, 32'h00a2f61e, 32'h00517c55,
        32'h0028be53, 32'h00145f2e, 32'h000a2f98, 32'h000517cc,
        32'h00028be6, 32'h000145f3, 32'h0000a2f9, 32'h0000517c,
        32'h000028be, 32'h0000145f, 32'h00000a2f, 32'h00000517,
        32'h0000028b, 32'h00000145, 32'h000000a2, 32'h00000051
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [PHASE_W-1:0]     z;
    } cordic_t;

    // quadrant pre-rotation; residual stays within +-1/8 turn
    function automatic cordic_t pre_rotate(logic [PHASE_W-1:0] ang);
        logic [PHASE_W-1:0] sum;
        logic [1:0]         q;
        cordic_t            c;
        sum = ang + EIGHTH;
        q   = sum[PHASE_W-1 -: 2];
        c.z = ang - (QUARTER * PHASE_W'(q));
        case (q)
            2'd0:    begin c.x = START_MAG;  c.y = '0;         end
            2'd1:    begin c.x = '0;         c.y = START_MAG;  end
            2'd2:    begin c.x = -START_MAG; c.y = '0;         end
            default: begin c.x = '0;         c.y = -START_MAG; end
        endcase
        return c;
    endfunction

    function automatic cordic_t rotate(cordic_t c, int i);
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        cordic_t                r;
        dx = c.y >>> i;
        dy = c.x >>> i;
        if (c.z[PHASE_W-1])
        begin
            r.x = c.x + dx;
            r.y = c.y - dy;
            r.z = c.z + ARC_TABLE[i];
        end
        else
        begin
            r.x = c.x - dx;
            r.y = c.y + dy;
            r.z = c.z - ARC_TABLE[i];
        end
        return r;
    endfunction

    function automatic prod_t link_mult(link_len_t len, logic signed [XY_W-1:0] t);
        return prod_t'($signed({1'b0, len})) * prod_t'(t);
    endfunction

    // round half up, then clamp to +-65535
    function automatic elbow_pos_t link_term(prod_t p);
        prod_t                   s;
        logic signed [RND_W-1:0] v;
        s = p + ROUND_HALF;
        v = s[PROD_W-1:FRAC_W];
        if (v > TERM_LIMIT)
            v = TERM_LIMIT;
        else if (v < -TERM_LIMIT)
            v = -TERM_LIMIT;
        return v[TERM_W-1:0];
    endfunction

endpackage

>>> hdl/pftk_if.sv
interface pftk_joint_if;
    logic            valid;
    logic            ready;
    pftk_pkg::angle_t shoulder_angle;
    pftk_pkg::angle_t elbow_angle;

    modport source (output valid, output shoulder_angle, output elbow_angle, input ready);
    modport sink   (input valid, input shoulder_angle, input elbow_angle, output ready);
endinterface

interface pftk_pos_if;
    logic                 valid;
    logic                 ready;
    pftk_pkg::elbow_pos_t elbow_x;
    pftk_pkg::elbow_pos_t elbow_y;
    pftk_pkg::tip_pos_t   tip_x;
    pftk_pkg::tip_pos_t   tip_y;

    modport source (output valid, output elbow_x, output elbow_y, output tip_x,
                    output tip_y, input ready);
    modport sink   (input valid, input elbow_x, input elbow_y, input tip_x,
                    input tip_y, output ready);
endinterface

interface pftk_cfg_if;
    logic                 valid;
    logic                 ready;
    pftk_pkg::cfg_index_t index;
    pftk_pkg::link_len_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/planar_two_link_forward_kinematics.sv
// Planar two-link arm forward kinematics.
// joints: one transaction carries shoulder_angle and elbow_angle (binary angles,
//   65536 per turn). pos: one transaction per joint transaction, giving
//   elbow_x/elbow_y and tip_x/tip_y in units of 1/256.
// cfg: index 0 writes first_link_length, index 1 second_link_length (Q8.8).
//   Always ready; write only while the pipeline is empty.
// Pipeline stages: 1 pre-rotation, 16 CORDIC micro-rotations, multiply,
//   round/clamp, sum.
// Throughput: one transaction per cycle while joints.ready is high; two CORDIC chains run side by side.
// Stall: when pos.ready is low, the result holds and empty stages still fill;
//   joints.ready drops only once every stage holds an item.
// Reset: pipeline empties, both link lengths return to 2.0 (512).
module planar_two_link_forward_kinematics (
    input  logic       clk,
    input  logic       rst_n,
    pftk_joint_if.sink joints,
    pftk_pos_if.source pos,
    pftk_cfg_if.sink   cfg
);
    import pftk_pkg::*;

    localparam int MUL_S = ROT_STAGES + 1;
    localparam int RND_S = ROT_STAGES + 2;
    localparam int OUT_S = ROT_STAGES + 3;

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] en;

    link_len_t len1_reg;
    link_len_t len2_reg;

    cordic_t c1_reg [0:ROT_STAGES];
    cordic_t c2_reg [0:ROT_STAGES];

    prod_t ex_prod_reg, ey_prod_reg, tx_prod_reg, ty_prod_reg;
    elbow_pos_t ex_term_reg, ey_term_reg, tx_term_reg, ty_term_reg;
    elbow_pos_t elbow_x_reg, elbow_y_reg;
    tip_pos_t   tip_x_reg, tip_y_reg;

    logic [PHASE_W-1:0] a1, a2, a12;
    logic               accept;

    // a stage advances when it is empty or its successor advances
    always_comb
    begin
        en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || pos.ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    assign joints.ready = en[0];
    assign accept       = joints.valid && en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int k = 0; k < PIPE_STAGES; k++)
                if (en[k])
                    valid_reg[k] <= (k == 0) ? joints.valid : valid_reg[(k == 0) ? 0 : k-1];
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len1_reg <= LINK_RESET;
            len2_reg <= LINK_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FIRST_LINK:  len1_reg <= cfg.data;
                REG_SECOND_LINK: len2_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    assign a1  = {joints.shoulder_angle, {(PHASE_W-IN_W){1'b0}}} & ANGLE_MASK;
    assign a2  = {joints.elbow_angle, {(PHASE_W-IN_W){1'b0}}} & ANGLE_MASK;
    assign a12 = (a1 + a2) & ANGLE_MASK;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            c1_reg[0] <= pre_rotate(a1);
            c2_reg[0] <= pre_rotate(a12);
        end
    end

    for (genvar k = 1; k <= ROT_STAGES; k++)
    begin : g_rot
        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                c1_reg[k] <= rotate(c1_reg[k-1], k - 1);
                c2_reg[k] <= rotate(c2_reg[k-1], k - 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[MUL_S])
        begin
            ex_prod_reg <= link_mult(len1_reg, c1_reg[ROT_STAGES].x);
            ey_prod_reg <= link_mult(len1_reg, c1_reg[ROT_STAGES].y);
            tx_prod_reg <= link_mult(len2_reg, c2_reg[ROT_STAGES].x);
            ty_prod_reg <= link_mult(len2_reg, c2_reg[ROT_STAGES].y);
        end
        if (en[RND_S])
        begin
            ex_term_reg <= link_term(ex_prod_reg);
            ey_term_reg <= link_term(ey_prod_reg);
            tx_term_reg <= link_term(tx_prod_reg);
            ty_term_reg <= link_term(ty_prod_reg);
        end
        if (en[OUT_S])
        begin
            elbow_x_reg <= ex_term_reg;
            elbow_y_reg <= ey_term_reg;
            tip_x_reg   <= TIP_W'(ex_term_reg) + TIP_W'(tx_term_reg);
            tip_y_reg   <= TIP_W'(ey_term_reg) + TIP_W'(ty_term_reg);
        end
    end

    assign pos.valid   = valid_reg[OUT_S];
    assign pos.elbow_x = elbow_x_reg;
    assign pos.elbow_y = elbow_y_reg;
    assign pos.tip_x   = tip_x_reg;
    assign pos.tip_y   = tip_y_reg;

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !joints.ready |-> (&valid_reg) && !pos.ready)
        else $error("input blocked while pipeline has room");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> valid_reg[0])
        else $error("accepted transaction not in first stage");

    a_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos.valid |-> (pos.elbow_x >= -17'sd65535) && (pos.elbow_y >= -17'sd65535))
        else $error("elbow position out of range");

    a_tip_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos.valid |-> (pos.tip_x >= -18'sd131070) && (pos.tip_x <= 18'sd131070)
                   && (pos.tip_y >= -18'sd131070) && (pos.tip_y <= 18'sd131070))
        else $error("tip position out of range");

endmodule
